// File: hdl/button_qualifier_auto_repeat_assert.svh
// Assertion helpers for the button qualifier block.
// All checks are sampled on clk and held off while rst_n is low.
`ifndef BUTTON_QUALIFIER_AUTO_REPEAT_ASSERT_SVH
`define BUTTON_QUALIFIER_AUTO_REPEAT_ASSERT_SVH

// cond must hold whenever trig holds
`define BQAR_ASSERT_IMPLIES(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("bqar check failed");

// bad must never hold
`define BQAR_ASSERT_NEVER(label, bad) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
        else $error("bqar check failed");

`endif

// File: hdl/bqar_pkg.sv
package bqar_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int NOW_BITS       = 32;
    localparam int DIR_BITS       = 4;
    localparam int EDGE_BITS      = 4;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_DATA_BITS-1:0] INITIAL_DELAY_RST = 16'd250;
    localparam logic [CFG_DATA_BITS-1:0] REPEAT_PERIOD_RST = 16'd100;

    typedef logic [DIR_BITS-1:0]      dir_t;
    typedef logic [NOW_BITS-1:0]      now_t;
    typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_INITIAL_DELAY = 2'd0,
        REG_REPEAT_PERIOD = 2'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_RIGHT = 3'd4
    } dir_code_t;

    // code of direction bit i
    localparam dir_code_t DIR_CODE [DIR_BITS] = '{DIR_UP, DIR_DOWN, DIR_LEFT, DIR_RIGHT};

    typedef struct packed {
        logic action_done;
        logic mark_done;
        logic holding_action;
        logic holding_mark;
        logic action_cancelled;
        logic mark_cancelled;
    } gesture_t;

    typedef struct packed {
        dir_t dir_keys;
        logic action_key;
        logic mark_key;
        logic confirm_key;
        logic hypo_key;
        logic pointer_key;
        logic music_key;
        now_t now_ms;
    } sample_t;

endpackage

// File: hdl/bqar_if.sv
interface bqar_sample_if;
    import bqar_pkg::*;

    logic valid;
    logic ready;
    dir_t dir_keys;
    logic action_key;
    logic mark_key;
    logic confirm_key;
    logic hypo_key;
    logic pointer_key;
    logic music_key;
    now_t now_ms;

    modport source (
        output valid, dir_keys, action_key, mark_key, confirm_key, hypo_key,
               pointer_key, music_key, now_ms,
        input  ready
    );
    modport sink (
        input  valid, dir_keys, action_key, mark_key, confirm_key, hypo_key,
               pointer_key, music_key, now_ms,
        output ready
    );
endinterface

interface bqar_result_if;
    import bqar_pkg::*;

    logic valid;
    logic ready;
    dir_t dir_pulse;
    logic action_done;
    logic mark_done;
    logic holding_action;
    logic holding_mark;
    logic action_cancelled;
    logic mark_cancelled;
    logic confirm_pulse;
    logic hypo_pulse;
    logic pointer_pulse;
    logic music_pulse;

    modport source (
        output valid, dir_pulse, action_done, mark_done, holding_action, holding_mark,
               action_cancelled, mark_cancelled, confirm_pulse, hypo_pulse,
               pointer_pulse, music_pulse,
        input  ready
    );
    modport sink (
        input  valid, dir_pulse, action_done, mark_done, holding_action, holding_mark,
               action_cancelled, mark_cancelled, confirm_pulse, hypo_pulse,
               pointer_pulse, music_pulse,
        output ready
    );
endinterface

// File: hdl/button_qualifier_auto_repeat.sv
// Button qualifier with typematic auto-repeat. Feed one sample of the button
// levels plus a free-running millisecond count per transfer on "sample"; each
// sample yields exactly one result on "result". One sample can be taken
// every clock cycle while the output is not stalled: the sample register and
// the result register form a two-stage pipeline, and the
// whole update (one wrapping time subtract and compare, the four-direction
// scan, the action/mark hold machine and the edge detectors) sits between
// them, with state written back as each sample moves to the result register.
// Directions: a fresh press pulses at once and becomes current; the current
// direction pulses again once held longer than initial_delay_ms, then every
// time more than repeat_period_ms has passed. Register 0 is the initial
// delay, register 1 the repeat period; other indexes are ignored. Write
// configuration only while the pipeline is empty.
`include "button_qualifier_auto_repeat_assert.svh"

module button_qualifier_auto_repeat #(
    parameter int TIME_BITS = bqar_pkg::TIME_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    bqar_sample_if.sink                           sample,
    bqar_result_if.source                         result,
    input  logic                                  cfg_we,
    input  logic [bqar_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  bqar_pkg::cfg_data_t                   cfg_data
);
    import bqar_pkg::*;

    // configuration
    cfg_data_t delay_reg;
    cfg_data_t period_reg;

    // stage 1: captured sample
    sample_t s1_reg;
    logic    s1_valid_reg;

    // stage 2: result register
    logic     out_valid_reg;
    dir_t     dir_pulse_reg;
    gesture_t gesture_reg;
    logic [EDGE_BITS-1:0] edge_pulse_reg;

    logic     adv;       // stage 1 moves to the result register, state commits
    logic     load;      // input transfer
    dir_t     dir_pulse_w;
    gesture_t gesture_w;
    logic [EDGE_BITS-1:0] edge_pulse_w;
    logic [EDGE_BITS-1:0] edge_levels;

    assign adv          = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || adv;
    assign load         = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg  <= INITIAL_DELAY_RST;
            period_reg <= REPEAT_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INITIAL_DELAY: delay_reg  <= cfg_data;
                REG_REPEAT_PERIOD: period_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_reg.dir_keys    <= sample.dir_keys;
            s1_reg.action_key  <= sample.action_key;
            s1_reg.mark_key    <= sample.mark_key;
            s1_reg.confirm_key <= sample.confirm_key;
            s1_reg.hypo_key    <= sample.hypo_key;
            s1_reg.pointer_key <= sample.pointer_key;
            s1_reg.music_key   <= sample.music_key;
            s1_reg.now_ms      <= sample.now_ms;
        end
        if (adv)
        begin
            dir_pulse_reg  <= dir_pulse_w;
            gesture_reg    <= gesture_w;
            edge_pulse_reg <= edge_pulse_w;
        end
    end

    bqar_dir #(
        .TIME_BITS (TIME_BITS)
    ) u_dir (
        .clk              (clk),
        .rst_n            (rst_n),
        .adv              (adv),
        .dir_keys         (s1_reg.dir_keys),
        .now_ms           (s1_reg.now_ms),
        .initial_delay_ms (delay_reg),
        .repeat_period_ms (period_reg),
        .dir_pulse        (dir_pulse_w)
    );

    bqar_gesture u_gesture (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .action_key (s1_reg.action_key),
        .mark_key   (s1_reg.mark_key),
        .status     (gesture_w)
    );

    assign edge_levels = {s1_reg.music_key, s1_reg.pointer_key,
                          s1_reg.hypo_key, s1_reg.confirm_key};

    bqar_edge u_edge (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .levels (edge_levels),
        .pulses (edge_pulse_w)
    );

    assign result.valid            = out_valid_reg;
    assign result.dir_pulse        = dir_pulse_reg;
    assign result.action_done      = gesture_reg.action_done;
    assign result.mark_done        = gesture_reg.mark_done;
    assign result.holding_action   = gesture_reg.holding_action;
    assign result.holding_mark     = gesture_reg.holding_mark;
    assign result.action_cancelled = gesture_reg.action_cancelled;
    assign result.mark_cancelled   = gesture_reg.mark_cancelled;
    assign result.confirm_pulse    = edge_pulse_reg[0];
    assign result.hypo_pulse       = edge_pulse_reg[1];
    assign result.pointer_pulse    = edge_pulse_reg[2];
    assign result.music_pulse      = edge_pulse_reg[3];

    // the shared lock keeps the two holds exclusive
    `BQAR_ASSERT_NEVER(a_hold_exclusive,
        out_valid_reg && gesture_reg.holding_action && gesture_reg.holding_mark)
    // a release pulse leaves its hold cleared
    `BQAR_ASSERT_IMPLIES(a_action_done_clears,
        out_valid_reg && gesture_reg.action_done, !gesture_reg.holding_action)
    `BQAR_ASSERT_IMPLIES(a_mark_done_clears,
        out_valid_reg && gesture_reg.mark_done, !gesture_reg.holding_mark)
    // a full pipeline with a stalled output takes no new sample
    `BQAR_ASSERT_IMPLIES(a_full_stall,
        s1_valid_reg && out_valid_reg && !result.ready, !sample.ready)
endmodule

// File: hdl/bqar_dir.sv
module bqar_dir #(
    parameter int TIME_BITS = bqar_pkg::TIME_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  bqar_pkg::dir_t      dir_keys,
    input  bqar_pkg::now_t      now_ms,
    input  bqar_pkg::cfg_data_t initial_delay_ms,
    input  bqar_pkg::cfg_data_t repeat_period_ms,
    output bqar_pkg::dir_t      dir_pulse
);
    import bqar_pkg::*;

    dir_t                 seen_reg, seen_next;
    dir_code_t            cur_reg, cur_next;
    logic                 rep_reg, rep_next;
    logic [TIME_BITS-1:0] mark_reg, mark_next;

    logic [TIME_BITS-1:0] now_t_w;
    logic [TIME_BITS-1:0] diff;
    logic [TIME_BITS-1:0] lim;
    logic                 fire;

    // one wrapping subtract and compare against the entry state; only the
    // entry current direction can reach the repeat check
    assign now_t_w = TIME_BITS'(now_ms);
    assign diff    = now_t_w - mark_reg;
    assign lim     = rep_reg ? TIME_BITS'(repeat_period_ms) : TIME_BITS'(initial_delay_ms);
    assign fire    = diff > lim;

    always_comb
    begin
        seen_next = seen_reg;
        cur_next  = cur_reg;
        rep_next  = rep_reg;
        mark_next = mark_reg;
        dir_pulse = '0;
        for (int i = 0; i < DIR_BITS; i++)
        begin
            if (dir_keys[i])
            begin
                if (!seen_next[i])
                begin
                    dir_pulse[i] = 1'b1;
                    seen_next[i] = 1'b1;
                    cur_next     = DIR_CODE[i];
                    rep_next     = 1'b0;
                    mark_next    = now_t_w;
                end
                else if (cur_next == DIR_CODE[i] && fire)
                begin
                    dir_pulse[i] = 1'b1;
                    rep_next     = 1'b1;
                    mark_next    = now_t_w;
                end
            end
            else
            begin
                seen_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            cur_reg  <= DIR_NONE;
            rep_reg  <= 1'b0;
            mark_reg <= '0;
        end
        else if (adv)
        begin
            seen_reg <= seen_next;
            cur_reg  <= cur_next;
            rep_reg  <= rep_next;
            mark_reg <= mark_next;
        end
    end
endmodule

// File: hdl/bqar_gesture.sv
module bqar_gesture (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               action_key,
    input  logic               mark_key,
    output bqar_pkg::gesture_t status
);
    import bqar_pkg::*;

    logic ahold_reg, ahold_next;
    logic mhold_reg, mhold_next;
    logic acan_reg, acan_next;
    logic mcan_reg, mcan_next;
    logic lock_reg, lock_next;
    logic adone, mdone;

    // checks run in order, each sees the previous one
    always_comb
    begin
        ahold_next = ahold_reg;
        mhold_next = mhold_reg;
        acan_next  = acan_reg;
        mcan_next  = mcan_reg;
        lock_next  = lock_reg;
        adone      = 1'b0;
        mdone      = 1'b0;
        if (action_key && !ahold_next && !mhold_next && !lock_next)
        begin
            ahold_next = 1'b1;
            lock_next  = 1'b1;
        end
        if (!action_key && ahold_next)
        begin
            ahold_next = 1'b0;
            adone      = 1'b1;
            lock_next  = 1'b0;
        end
        if (mark_key && !ahold_next && !mhold_next && !lock_next)
        begin
            mhold_next = 1'b1;
            lock_next  = 1'b1;
        end
        if (!mark_key && mhold_next)
        begin
            mhold_next = 1'b0;
            mdone      = 1'b1;
            lock_next  = 1'b0;
        end
        if (mark_key && ahold_next && !mhold_next)
        begin
            ahold_next = 1'b0;
            acan_next  = 1'b1;
            lock_next  = 1'b1;
        end
        if (!mark_key && !action_key && acan_next)
        begin
            acan_next = 1'b0;
            lock_next = 1'b0;
        end
        if (action_key && !ahold_next && mhold_next)
        begin
            mhold_next = 1'b0;
            mcan_next  = 1'b1;
            lock_next  = 1'b1;
        end
        if (!mark_key && !action_key && mcan_next)
        begin
            mcan_next = 1'b0;
            lock_next = 1'b0;
        end
    end

    assign status.action_done      = adone;
    assign status.mark_done        = mdone;
    assign status.holding_action   = ahold_next;
    assign status.holding_mark     = mhold_next;
    assign status.action_cancelled = acan_next;
    assign status.mark_cancelled   = mcan_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ahold_reg <= 1'b0;
            mhold_reg <= 1'b0;
            acan_reg  <= 1'b0;
            mcan_reg  <= 1'b0;
            lock_reg  <= 1'b0;
        end
        else if (adv)
        begin
            ahold_reg <= ahold_next;
            mhold_reg <= mhold_next;
            acan_reg  <= acan_next;
            mcan_reg  <= mcan_next;
            lock_reg  <= lock_next;
        end
    end
endmodule

// File: hdl/bqar_edge.sv
module bqar_edge (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic [bqar_pkg::EDGE_BITS-1:0]     levels,
    output logic [bqar_pkg::EDGE_BITS-1:0]     pulses
);
    import bqar_pkg::*;

    // bit0 confirm, bit1 hypo, bit2 pointer, bit3 music
    logic [EDGE_BITS-1:0] locks_reg;

    assign pulses = levels & ~locks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locks_reg <= '0;
        end
        else if (adv)
        begin
            locks_reg <= levels;
        end
    end
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

// Testbench for button_qualifier_auto_repeat.
//
// Every transfer on the sample channel yields exactly one result. A software
// copy of the qualifier (qualify_sample) runs on each accepted sample and
// queues what the block must return. The result side pops the oldest entry
// and compares it field by field.
//
// Plan:
//   - short directed table: after-reset values, repeat timing at the exact
//     delay/period bounds, stale current direction, wrap of the ms counter,
//     action/mark hold, release and cancel paths, edge pulses
//   - random runs over several delay/period settings, extremes included,
//     plus writes to the spare register indexes, which must change nothing
//   - one run where the result side holds off for a long stretch so the
//     pipeline fills and the sample side backs up
module tb;
    import bqar_pkg::*;

    // Extra cycles after the result queue empties settle the pipeline before a
    // register write or the final verdict.
    localparam int SETTLE_CYCLES  = 6;
    // Long result-side hold-off for the backpressure run.
    localparam int STALL_CYCLES   = 300;
    // Quiet cycles allowed with no transfer on either channel. The slowest
    // correct case is the long hold-off above plus a long random gap.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    // Register indexes the block has no register for.
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

    localparam dir_t D_UP    = 4'b0001;
    localparam dir_t D_DOWN  = 4'b0010;
    localparam dir_t D_LEFT  = 4'b0100;
    localparam dir_t D_NONE  = 4'b0000;
    localparam dir_t D_ALL   = 4'b1111;

    // Button bits in sample_t order: action, mark, confirm, hypo, pointer, music.
    localparam logic [5:0] K_NONE    = 6'b000000;
    localparam logic [5:0] K_ACTION  = 6'b100000;
    localparam logic [5:0] K_MARK    = 6'b010000;
    localparam logic [5:0] K_EDGES   = 6'b001111;
    localparam logic [5:0] K_ALL     = 6'b111111;

    typedef struct packed {
        dir_t dir_pulse;
        logic action_done;
        logic mark_done;
        logic holding_action;
        logic holding_mark;
        logic action_cancelled;
        logic mark_cancelled;
        logic confirm_pulse;
        logic hypo_pulse;
        logic pointer_pulse;
        logic music_pulse;
    } outcome_t;

    typedef struct {
        sample_t  s;
        bit       typed;
        outcome_t want;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    cfg_data_t               cfg_data;

    bqar_sample_if smp_ch ();
    bqar_result_if res_ch ();

    button_qualifier_auto_repeat dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---- qualifier copy: configuration and state ----
    cfg_data_t delay_cfg;
    cfg_data_t period_cfg;
    dir_t      dirs_down;
    dir_code_t active_dir;
    bit        repeat_on;
    now_t      last_event;
    bit        act_hold, mrk_hold, act_cancel, mrk_cancel, gest_lock;
    logic [EDGE_BITS-1:0] level_seen;

    outcome_t  pending_outcomes[$];
    stim_row_t directed_rows[$];

    // random stimulus state: keys currently held and the running ms clock
    dir_t       held_dirs;
    logic [5:0] held_btn;
    now_t       clk_ms;

    // shared controls between the stimulus and the result side
    bit in_steady;
    bit out_steady;
    bit stall_req;
    int fail_count;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic reset_model();
        delay_cfg  = INITIAL_DELAY_RST;
        period_cfg = REPEAT_PERIOD_RST;
        dirs_down  = '0;
        active_dir = DIR_NONE;
        repeat_on  = 1'b0;
        last_event = '0;
        act_hold   = 1'b0;
        mrk_hold   = 1'b0;
        act_cancel = 1'b0;
        mrk_cancel = 1'b0;
        gest_lock  = 1'b0;
        level_seen = '0;
    endtask

    // One sample through the qualifier; updates the model state.
    function automatic outcome_t qualify_sample(sample_t s);
        outcome_t  o;
        now_t      elapsed;
        cfg_data_t bound;
        int        i;
        o = '0;
        // Directions in up, down, left, right order; a later fresh press
        // takes over as the current direction.
        for (i = 0; i < DIR_BITS; i++) begin
            if (s.dir_keys[i]) begin
                if (!dirs_down[i]) begin
                    o.dir_pulse[i] = 1'b1;
                    dirs_down[i]   = 1'b1;
                    active_dir     = DIR_CODE[i];
                    repeat_on      = 1'b0;
                    last_event     = s.now_ms;
                end else if (active_dir == DIR_CODE[i]) begin
                    // wrapping difference, strictly greater than the bound
                    elapsed = s.now_ms - last_event;
                    bound   = repeat_on ? period_cfg : delay_cfg;
                    if (elapsed > now_t'(bound)) begin
                        last_event     = s.now_ms;
                        repeat_on      = 1'b1;
                        o.dir_pulse[i] = 1'b1;
                    end
                end
            end else begin
                // released: current direction stays as it was (stale)
                dirs_down[i] = 1'b0;
            end
        end

        // Hold / release / cancel, each step sees the ones before it.
        if (s.action_key && !act_hold && !mrk_hold && !gest_lock) begin
            act_hold  = 1'b1;
            gest_lock = 1'b1;
        end
        if (!s.action_key && act_hold) begin
            act_hold      = 1'b0;
            o.action_done = 1'b1;
            gest_lock     = 1'b0;
        end
        if (s.mark_key && !act_hold && !mrk_hold && !gest_lock) begin
            mrk_hold  = 1'b1;
            gest_lock = 1'b1;
        end
        if (!s.mark_key && mrk_hold) begin
            mrk_hold    = 1'b0;
            o.mark_done = 1'b1;
            gest_lock   = 1'b0;
        end
        if (s.mark_key && act_hold && !mrk_hold) begin
            act_hold   = 1'b0;
            act_cancel = 1'b1;
            gest_lock  = 1'b1;
        end
        if (!s.mark_key && !s.action_key && act_cancel) begin
            act_cancel = 1'b0;
            gest_lock  = 1'b0;
        end
        if (s.action_key && !act_hold && mrk_hold) begin
            mrk_hold   = 1'b0;
            mrk_cancel = 1'b1;
            gest_lock  = 1'b1;
        end
        if (!s.mark_key && !s.action_key && mrk_cancel) begin
            mrk_cancel = 1'b0;
            gest_lock  = 1'b0;
        end
        o.holding_action   = act_hold;
        o.holding_mark     = mrk_hold;
        o.action_cancelled = act_cancel;
        o.mark_cancelled   = mrk_cancel;

        o.confirm_pulse = s.confirm_key && !level_seen[0];
        o.hypo_pulse    = s.hypo_key    && !level_seen[1];
        o.pointer_pulse = s.pointer_key && !level_seen[2];
        o.music_pulse   = s.music_key   && !level_seen[3];
        level_seen = {s.music_key, s.pointer_key, s.hypo_key, s.confirm_key};
        return o;
    endfunction

    function automatic sample_t mk(dir_t d, logic [5:0] keys, now_t t);
        return {d, keys, t};
    endfunction

    function automatic void add(sample_t s);
        stim_row_t r;
        r.s     = s;
        r.typed = 1'b0;
        r.want  = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_typed(sample_t s, outcome_t w);
        stim_row_t r;
        r.s     = s;
        r.typed = 1'b1;
        r.want  = w;
        directed_rows.push_back(r);
    endfunction

    // Directed table; expected values typed in only where obvious.
    // Runs right after reset with delay 250 and period 100.
    task automatic build_directed();
        outcome_t w;
        w = '0;
        add_typed(mk(D_NONE, K_NONE, 32'd0), w);
        w.dir_pulse = D_UP;
        add_typed(mk(D_UP, K_NONE, 32'd1000), w);      // fresh press
        w = '0;
        add_typed(mk(D_UP, K_NONE, 32'd1250), w);      // exactly the delay: no repeat
        add(mk(D_UP, K_NONE, 32'd1251));               // first repeat
        add(mk(D_UP, K_NONE, 32'd1351));               // exactly the period
        add(mk(D_UP, K_NONE, 32'd1352));
        add(mk(D_ALL, K_NONE, 32'd2000));              // later fresh press wins
        add(mk(D_ALL, K_NONE, 32'd2101));
        add(mk(D_UP, K_NONE, 32'd3000));               // stale current: up stays quiet
        add(mk(D_UP | D_DOWN, K_NONE, 32'd3001));
        add(mk(D_LEFT, K_NONE, 32'hFFFF_FF00));
        add(mk(D_LEFT, K_NONE, 32'hFFFF_FFFF));
        add(mk(D_LEFT, K_NONE, 32'h0000_0100));        // ms counter wrapped
        w = '0;
        w.holding_action = 1'b1;
        add_typed(mk(D_NONE, K_ACTION, 32'd5), w);
        add(mk(D_NONE, K_ACTION | K_MARK, 32'd6));     // mark cancels action
        add(mk(D_NONE, K_MARK, 32'd7));
        add(mk(D_NONE, K_NONE, 32'd8));                // cancel clears
        add(mk(D_NONE, K_MARK, 32'd9));
        add(mk(D_NONE, K_NONE, 32'd10));               // mark released
        add(mk(D_NONE, K_MARK, 32'd11));
        add(mk(D_NONE, K_MARK | K_ACTION, 32'd12));    // action cancels mark
        add(mk(D_NONE, K_ACTION, 32'd13));
        add(mk(D_NONE, K_NONE, 32'd14));
        add(mk(D_NONE, K_ACTION | K_MARK, 32'd15));    // both in one sample
        add(mk(D_NONE, K_NONE, 32'd16));
        add(mk(D_NONE, K_ACTION, 32'd17));
        add(mk(D_NONE, K_NONE, 32'd18));               // action released
        w = '0;
        {w.confirm_pulse, w.hypo_pulse, w.pointer_pulse, w.music_pulse} = 4'b1111;
        add_typed(mk(D_NONE, K_EDGES, 32'd19), w);
        add(mk(D_ALL, K_ALL, 32'hFFFF_FFFF));
        add(mk(D_NONE, K_NONE, 32'd0));
    endtask

    // Idle length: mostly none, some short, a few long.
    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Mostly held keys that change now and then, with time steps sized to
    // the current delay/period so repeats actually fire; some pure noise.
    function automatic sample_t random_sample();
        int unsigned scale;
        int unsigned step;
        int          r;
        int          i;
        scale = (delay_cfg > period_cfg) ? int'(delay_cfg) : int'(period_cfg);
        scale = scale / 3 + 2;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            held_dirs = dir_t'($urandom);
            held_btn  = 6'($urandom);
            clk_ms    = $urandom;
        end else begin
            for (i = 0; i < DIR_BITS; i++)
                if ($urandom_range(0, 11) == 0)
                    held_dirs[i] = ~held_dirs[i];
            for (i = 0; i < 6; i++)
                if ($urandom_range(0, 6) == 0)
                    held_btn[i] = ~held_btn[i];
            r = $urandom_range(0, 99);
            if (r < 10)
                step = 0;
            else if (r < 88)
                step = $urandom_range(0, scale);
            else
                step = $urandom_range(scale, 3 * scale);
            clk_ms = clk_ms + now_t'(step);
        end
        return {held_dirs, held_btn, clk_ms};
    endfunction

    // Offer one sample; on the transfer, queue what it must produce.
    task automatic send(sample_t s, bit typed, outcome_t want);
        outcome_t predicted;
        int       gap;
        gap = pick_gap(in_steady);
        if (gap > 0) begin
            smp_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp_ch.valid <= 1'b1;
        {smp_ch.dir_keys, smp_ch.action_key, smp_ch.mark_key, smp_ch.confirm_key,
         smp_ch.hypo_key, smp_ch.pointer_key, smp_ch.music_key, smp_ch.now_ms} <= s;
        @(posedge clk);
        while (!smp_ch.ready)
            @(posedge clk);
        predicted = qualify_sample(s);
        pending_outcomes.push_back(typed ? want : predicted);
    endtask

    task automatic run_random(int count);
        int k;
        for (k = 0; k < count; k++)
            send(random_sample(), 1'b0, '0);
    endtask

    // Stop offering and wait for the pipeline to empty.
    task automatic drain();
        smp_ch.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers, then a spare index that must be ignored.
    task automatic set_config(cfg_data_t delay, cfg_data_t period,
                              logic [CFG_IDX_BITS-1:0] spare);
        cfg_we    <= 1'b1;
        cfg_index <= REG_INITIAL_DELAY;
        cfg_data  <= delay;
        @(posedge clk);
        delay_cfg = delay;
        cfg_index <= REG_REPEAT_PERIOD;
        cfg_data  <= period;
        @(posedge clk);
        period_cfg = period;
        cfg_index <= spare;
        cfg_data  <= cfg_data_t'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ---- stimulus ----
    initial begin
        int k;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_INITIAL_DELAY;
        cfg_data     <= '0;
        smp_ch.valid <= 1'b0;
        {smp_ch.dir_keys, smp_ch.action_key, smp_ch.mark_key, smp_ch.confirm_key,
         smp_ch.hypo_key, smp_ch.pointer_key, smp_ch.music_key, smp_ch.now_ms} <= '0;
        in_steady  = 1'b0;
        out_steady = 1'b0;
        stall_req  = 1'b0;
        held_dirs  = '0;
        held_btn   = '0;
        clk_ms     = '0;
        reset_model();
        build_directed();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send(directed_rows[k].s, directed_rows[k].typed, directed_rows[k].want);
        drain();

        // Default timing, with a full pause of the sample side midway.
        run_random(100);
        drain();
        run_random(100);
        drain();

        // Extremes: zero delay/period repeats on every later sample whose ms count moved on.
        set_config('0, '0, REG_SPARE_A);
        run_random(200);
        drain();
        set_config('1, '1, REG_SPARE_B);
        run_random(180);
        drain();
        set_config('1, '0, REG_SPARE_A);
        run_random(120);
        drain();
        set_config('0, '1, REG_SPARE_B);
        run_random(120);
        drain();

        // Backpressure: result side holds off while samples keep coming.
        set_config(cfg_data_t'($urandom_range(0, 400)), cfg_data_t'($urandom_range(0, 200)),
                   REG_SPARE_A);
        in_steady = 1'b1;
        stall_req = 1'b1;
        run_random(200);
        in_steady = 1'b0;
        drain();

        // Back-to-back transfers on both sides.
        in_steady  = 1'b1;
        out_steady = 1'b1;
        run_random(80);
        in_steady  = 1'b0;
        out_steady = 1'b0;
        drain();

        for (k = 0; k < 3; k++) begin
            set_config(cfg_data_t'($urandom_range(0, 600)),
                       cfg_data_t'($urandom_range(0, 300)), REG_SPARE_B);
            run_random(100);
            drain();
        end

        if (fail_count == 0 && pending_outcomes.size() == 0)
            $display("** button_qualifier_auto_repeat: PASSED **");
        else
            $display("** button_qualifier_auto_repeat: FAILED **");
        $finish;
    end

    // ---- result side: random ready, long hold-off on request, checking ----
    initial begin
        int       hold_left;
        int       gap_left;
        outcome_t got;
        outcome_t want;
        hold_left    = 0;
        gap_left     = 0;
        fail_count   = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready) begin
                got = {res_ch.dir_pulse, res_ch.action_done, res_ch.mark_done,
                       res_ch.holding_action, res_ch.holding_mark,
                       res_ch.action_cancelled, res_ch.mark_cancelled,
                       res_ch.confirm_pulse, res_ch.hypo_pulse,
                       res_ch.pointer_pulse, res_ch.music_pulse};
                if (pending_outcomes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result transfer: dir %b flags %b",
                                 got.dir_pulse, got[9:0]);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        // flags: done a/m, hold a/m, cancel a/m, confirm hypo pointer music
                        if (fail_count <= MAX_REPORTS)
                            $display("result mismatch: exp dir %b flags %b, got dir %b flags %b",
                                     want.dir_pulse, want[9:0], got.dir_pulse, got[9:0]);
                    end
                end
            end

            if (stall_req) begin
                stall_req = 1'b0;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                res_ch.ready <= 1'b0;
            end else begin
                gap_left = pick_gap(out_steady);
                if (gap_left > 0) begin
                    gap_left--;
                    res_ch.ready <= 1'b0;
                end else begin
                    res_ch.ready <= 1'b1;
                end
            end
        end
    end

    // ---- watchdog: too long with no transfer on either channel ----
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("** button_qualifier_auto_repeat: FAILED **");
        $finish;
    end

endmodule
